[rtl/assert_macros.svh]
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mpsm_pkg.sv]
package mpsm_pkg;

    localparam int DEF_MAX_WORDS = 8;
    localparam int DEF_WORD_BITS = 64;

    // Fixed field widths on the ports
    localparam int FIELD_W      = 64;
    localparam int COUNT_W      = 4;
    localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
    localparam int TOP_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;

    localparam logic [COUNT_W-1:0] WORD_COUNT_RESET = COUNT_W'(8);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MSW_FIRST  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [FIELD_W-1:0] a_word;
        logic [FIELD_W-1:0] b_word;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] product_word;
        logic               last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_MUL,
        S_COL,
        S_LAST,
        S_RD,
        S_OUT
    } t_state;

endpackage

[rtl/multiword_product_scan_multiplier.sv]
// Multi-word unsigned multiplier, product scanning (column-wise schoolbook).
// Input channel (i_in_valid / o_in_ready / i_in_data): each request carries
// one word of operand A and one of operand B, in memory order. After n
// requests (n = word_count, 0 read as 1, capped at MAX_WORDS and at 15) the product runs.
// Output channel (o_out_valid / i_out_ready / o_out_data): 2n product words in
// memory order, last_word set on the final one. msw_first selects whether
// memory index 0 is the most significant word, for operands and product.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
// always ready; write it only while no run is in progress.
// One shared 32x32 multiplier forms each 64x64 word product from its four
// half-word products in turn. Each column's terms are multiplied and summed,
// then the column word is written to the product store; after the last column
// the top word is written and the product words are read out one by one.
// Inputs are not taken during a run; loading starts again once the final word is sent on.
// The output register lets the next run start loading while the final word
// still waits; a stalled receiver holds the block in the output phase.
// Reset (synchronous, active low) returns to loading with a zero load count,
// word_count 8 and msw_first 0. Operand stores are not cleared.
`include "assert_macros.svh"

module multiword_product_scan_multiplier #(
    parameter int MAX_WORDS = mpsm_pkg::DEF_MAX_WORDS,
    parameter int WORD_BITS = mpsm_pkg::DEF_WORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mpsm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mpsm_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mpsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mpsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mpsm_pkg::*;

    localparam int W       = WORD_BITS;
    localparam int H       = (W + 1) / 2;
    localparam int PP_W    = 2 * H;
    localparam int ACC_W   = 2 * W + TOP_W;
    localparam int CNT_W   = COUNT_W;
    localparam int COL_W   = CNT_W + 1;
    localparam int IDX_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int PIDX_W  = $clog2(2 * MAX_WORDS);
    localparam int AW_MAX  = (IDX_W > COL_W) ? IDX_W : COL_W;
    localparam int PAW_MAX = (PIDX_W > COL_W) ? PIDX_W : COL_W;

    localparam logic [CNT_W-1:0] MAX_CNT =
        CNT_W'((MAX_WORDS > COUNT_MAX) ? COUNT_MAX : MAX_WORDS);
    localparam logic [1:0] PHASE_LAST = 2'd3;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_word_count;
    logic               r_msw_first;
    logic [CNT_W-1:0]   r_load_cnt;
    logic [COL_W-1:0]   r_col;
    logic [CNT_W-1:0]   r_j;
    logic [1:0]         r_phase;
    logic [1:0]         r_pp_ph;
    logic               r_pp_vld;
    logic [PP_W-1:0]    r_pp;
    logic [ACC_W-1:0]   r_acc;
    logic [COL_W-1:0]   r_k;
    logic               r_out_vld;
    t_out_item          r_out_data;

    logic [CNT_W-1:0]   n_eff;
    logic [COL_W-1:0]   total;
    logic               in_acc;
    logic               load_done;
    logic [CNT_W-1:0]   j_hi;
    logic [COL_W-1:0]   col_next;
    logic [CNT_W-1:0]   j_lo_next;
    logic               col_done;
    logic               last_col;
    logic               is_last;
    logic               out_load;

    logic [CNT_W-1:0]   f_j;
    logic [AW_MAX-1:0]  fj_ext;
    logic [AW_MAX-1:0]  n_ext;
    logic [AW_MAX-1:0]  a_m;
    logic [AW_MAX-1:0]  b_idx;
    logic [AW_MAX-1:0]  b_m;
    logic [AW_MAX-1:0]  ld_ext;
    logic               ld_we;
    logic               ab_re;
    logic [W-1:0]       a_rdata;
    logic [W-1:0]       b_rdata;
    logic [H-1:0]       a_part;
    logic [H-1:0]       b_part;
    logic [ACC_W-1:0]   pp_sh;
    logic [ACC_W-1:0]   n_sum;

    logic               prod_we;
    logic [PAW_MAX-1:0] prod_waddr_ext;
    logic [W-1:0]       prod_wdata;
    logic               prod_re;
    logic [PAW_MAX-1:0] prod_raddr_ext;
    logic [W-1:0]       prod_rdata;

    // Effective word count
    always_comb begin
        if (r_word_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_word_count > MAX_CNT) begin
            n_eff = MAX_CNT;
        end else begin
            n_eff = r_word_count;
        end
    end

    assign total     = {n_eff, 1'b0};
    assign in_acc    = i_in_valid && o_in_ready;
    assign load_done = (COL_W'(r_load_cnt) + COL_W'(1)) >= COL_W'(n_eff);

    // Column term bounds
    assign j_hi      = (r_col < COL_W'(n_eff)) ? CNT_W'(r_col) : (n_eff - CNT_W'(1));
    assign col_next  = r_col + COL_W'(1);
    assign j_lo_next = (col_next >= COL_W'(n_eff)) ?
                       CNT_W'(col_next - COL_W'(n_eff) + COL_W'(1)) : '0;
    assign col_done  = (r_j == j_hi);
    assign last_col  = (r_col == total - COL_W'(2));
    assign is_last   = (r_k == total - COL_W'(1));
    assign out_load  = (r_state == S_OUT) && (!r_out_vld || i_out_ready);

    // Operand fetch addresses: next term during the last multiply phase
    assign f_j    = (r_state == S_MUL) ? (r_j + CNT_W'(1)) : r_j;
    assign fj_ext = AW_MAX'(f_j);
    assign n_ext  = AW_MAX'(n_eff);
    assign a_m    = r_msw_first ? (n_ext - AW_MAX'(1) - fj_ext) : fj_ext;
    assign b_idx  = AW_MAX'(r_col) - fj_ext;
    assign b_m    = r_msw_first ? (n_ext - AW_MAX'(1) - b_idx) : b_idx;
    assign ld_ext = AW_MAX'(r_load_cnt);
    assign ld_we  = in_acc && (32'(r_load_cnt) < MAX_WORDS);

    // Half-word operand selection for the shared multiplier
    assign a_part = r_phase[1] ? H'(a_rdata[W-1:H]) : a_rdata[H-1:0];
    assign b_part = r_phase[0] ? H'(b_rdata[W-1:H]) : b_rdata[H-1:0];

    always_comb begin
        case (r_pp_ph)
            2'd0:    pp_sh = ACC_W'(r_pp);
            2'd3:    pp_sh = ACC_W'(r_pp) << (2 * H);
            default: pp_sh = ACC_W'(r_pp) << H;
        endcase
    end

    assign n_sum = r_acc + (r_pp_vld ? pp_sh : '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && load_done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_MUL;
            S_MUL: begin
                if (r_phase == PHASE_LAST && col_done) begin
                    n_state = S_COL;
                end
            end
            S_COL:  n_state = last_col ? S_LAST : S_FETCH;
            S_LAST: n_state = S_RD;
            S_RD:   n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = is_last ? S_LOAD : S_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Datapath controls
    always_comb begin
        o_in_ready     = 1'b0;
        ab_re          = 1'b0;
        prod_we        = 1'b0;
        prod_waddr_ext = PAW_MAX'(r_col);
        prod_wdata     = n_sum[W-1:0];
        prod_re        = 1'b0;
        unique case (r_state)
            S_LOAD:  o_in_ready = 1'b1;
            S_FETCH: ab_re = 1'b1;
            S_MUL:   ab_re = (r_phase == PHASE_LAST) && !col_done;
            S_COL:   prod_we = 1'b1;
            S_LAST: begin
                prod_we        = 1'b1;
                prod_waddr_ext = PAW_MAX'(total - COL_W'(1));
                prod_wdata     = r_acc[W-1:0];
            end
            S_RD:    prod_re = 1'b1;
            S_OUT:   prod_re = 1'b0;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign prod_raddr_ext = r_msw_first ? PAW_MAX'(total - COL_W'(1) - r_k) : PAW_MAX'(r_k);

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_word_count <= WORD_COUNT_RESET;
            r_msw_first  <= 1'b0;
            r_load_cnt   <= '0;
            r_col        <= '0;
            r_j          <= '0;
            r_phase      <= '0;
            r_pp_ph      <= '0;
            r_pp_vld     <= 1'b0;
            r_acc        <= '0;
            r_k          <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pp_vld <= (r_state == S_MUL);

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_WORD_COUNT: r_word_count <= i_cfg_data[CNT_W-1:0];
                    REG_MSW_FIRST:  r_msw_first  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_load_cnt <= load_done ? '0 : (r_load_cnt + CNT_W'(1));
                if (load_done) begin
                    r_col <= '0;
                    r_j   <= '0;
                    r_acc <= '0;
                end
            end

            if (r_state == S_FETCH) begin
                r_phase <= '0;
            end

            if (r_state == S_MUL) begin
                r_pp_ph <= r_phase;
                r_phase <= r_phase + 2'd1;
                r_acc   <= n_sum;
                if (r_phase == PHASE_LAST && !col_done) begin
                    r_j <= r_j + CNT_W'(1);
                end
            end

            // Retire the column word and shift the accumulator down one word
            if (r_state == S_COL) begin
                r_acc <= n_sum >> W;
                if (!last_col) begin
                    r_col <= col_next;
                    r_j   <= j_lo_next;
                end
            end

            if (r_state == S_LAST) begin
                r_k <= '0;
            end

            if (out_load) begin
                r_k       <= r_k + COL_W'(1);
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_pp <= PP_W'(a_part) * PP_W'(b_part);
        end
        if (out_load) begin
            r_out_data.product_word <= FIELD_W'(prod_rdata);
            r_out_data.last_word    <= is_last;
        end
    end

    mpsm_ram #(
        .WIDTH  (W),
        .DEPTH  (MAX_WORDS),
        .ADDR_W (IDX_W)
    ) u_a_store (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (ld_ext[IDX_W-1:0]),
        .i_wdata (i_in_data.a_word[W-1:0]),
        .i_re    (ab_re),
        .i_raddr (a_m[IDX_W-1:0]),
        .o_rdata (a_rdata)
    );

    mpsm_ram #(
        .WIDTH  (W),
        .DEPTH  (MAX_WORDS),
        .ADDR_W (IDX_W)
    ) u_b_store (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (ld_ext[IDX_W-1:0]),
        .i_wdata (i_in_data.b_word[W-1:0]),
        .i_re    (ab_re),
        .i_raddr (b_m[IDX_W-1:0]),
        .o_rdata (b_rdata)
    );

    mpsm_ram #(
        .WIDTH  (W),
        .DEPTH  (2 * MAX_WORDS),
        .ADDR_W (PIDX_W)
    ) u_prod_store (
        .i_clk   (i_clk),
        .i_we    (prod_we),
        .i_waddr (prod_waddr_ext[PIDX_W-1:0]),
        .i_wdata (prod_wdata),
        .i_re    (prod_re),
        .i_raddr (prod_raddr_ext[PIDX_W-1:0]),
        .o_rdata (prod_rdata)
    );

    `ASSERT_NEXT(a_pp_follows_mul, i_clk, i_rst_n, (r_state == S_MUL), r_pp_vld, "partial product lost")
    `ASSERT_IMPLIES(a_term_in_column, i_clk, i_rst_n, (r_state == S_MUL), (r_j <= j_hi), "term index past column")
    `ASSERT_IMPLIES(a_emit_in_range, i_clk, i_rst_n, (r_state == S_OUT), (r_k < total), "product index out of range")

endmodule

[rtl/mpsm_ram.sv]
module mpsm_ram #(
    parameter int WIDTH  = mpsm_pkg::DEF_WORD_BITS,
    parameter int DEPTH  = mpsm_pkg::DEF_MAX_WORDS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    import mpsm_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
